// ----- rtl/lsps_pkg.sv -----
`default_nettype none

package lsps_pkg;

   localparam int SENSOR_W = 10;
   localparam int DUTY_W   = 11;
   localparam int CORR_W   = 17;
   localparam int ERR_W    = 6;
   localparam int DIFF_W   = 7;
   localparam int SUM_W    = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   localparam logic [SENSOR_W-1:0] LINE_LEVEL = 10'd1000;
   localparam logic signed [ERR_W-1:0] LOST_ERR = 6'sd25;
   localparam logic signed [ERR_W-1:0] SIDE_ERR = 6'sd10;

   localparam logic [6:0] BASE_DUTY_RST   = 7'd68;
   localparam logic [6:0] MIN_DUTY_RST    = 7'd55;
   localparam logic [6:0] MAX_DUTY_RST    = 7'd85;
   localparam logic [7:0] PROP_GAIN_RST   = 8'd56;
   localparam logic [7:0] INTEG_GAIN_RST  = 8'd0;
   localparam logic [7:0] DERIV_GAIN_RST  = 8'd20;
   localparam logic [6:0] INTEG_LIMIT_RST = 7'd30;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_DUTY   = 3'd0,
      CSR_MIN_DUTY    = 3'd1,
      CSR_MAX_DUTY    = 3'd2,
      CSR_PROP_GAIN   = 3'd3,
      CSR_INTEG_GAIN  = 3'd4,
      CSR_DERIV_GAIN  = 3'd5,
      CSR_INTEG_LIMIT = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [6:0] base_duty;
      logic [6:0] min_duty;
      logic [6:0] max_duty;
      logic [7:0] prop_gain;
      logic [7:0] integ_gain;
      logic [7:0] deriv_gain;
      logic [6:0] integ_limit;
   } csr_type;

   typedef struct packed {
      logic [SENSOR_W-1:0] far_left;
      logic [SENSOR_W-1:0] left;
      logic [SENSOR_W-1:0] mid;
      logic [SENSOR_W-1:0] right;
      logic [SENSOR_W-1:0] far_right;
   } frame_type;

   // error stage handed to the PID stage
   typedef struct packed {
      logic signed [ERR_W-1:0]  err;
      logic signed [DIFF_W-1:0] diff;
      logic signed [SUM_W-1:0]  sum;
   } err_stage_type;

endpackage

`default_nettype wire

// ----- rtl/lsps_if.sv -----
`default_nettype none

interface lsps_req_if;
   import lsps_pkg::*;
   logic                valid;
   logic                ready;
   logic [SENSOR_W-1:0] sensor_far_left;
   logic [SENSOR_W-1:0] sensor_left;
   logic [SENSOR_W-1:0] sensor_mid;
   logic [SENSOR_W-1:0] sensor_right;
   logic [SENSOR_W-1:0] sensor_far_right;

   modport source (output valid, sensor_far_left, sensor_left, sensor_mid, sensor_right,
                   sensor_far_right, input ready);
   modport sink   (input valid, sensor_far_left, sensor_left, sensor_mid, sensor_right,
                   sensor_far_right, output ready);
endinterface

interface lsps_rsp_if;
   import lsps_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [DUTY_W-1:0]        left_duty_q4;
   logic [DUTY_W-1:0]        right_duty_q4;
   logic signed [CORR_W-1:0] correction_q4;
   logic signed [ERR_W-1:0]  position_error;

   modport source (output valid, left_duty_q4, right_duty_q4, correction_q4, position_error,
                   input ready);
   modport sink   (input valid, left_duty_q4, right_duty_q4, correction_q4, position_error,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/lsps_csr.sv -----
`default_nettype none

module lsps_csr import lsps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output csr_type               cfg
);

   csr_type cfg_ff;
   csr_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BASE_DUTY:   cfg_in.base_duty   = csr_wdata[6:0];
            CSR_MIN_DUTY:    cfg_in.min_duty    = csr_wdata[6:0];
            CSR_MAX_DUTY:    cfg_in.max_duty    = csr_wdata[6:0];
            CSR_PROP_GAIN:   cfg_in.prop_gain   = csr_wdata;
            CSR_INTEG_GAIN:  cfg_in.integ_gain  = csr_wdata;
            CSR_DERIV_GAIN:  cfg_in.deriv_gain  = csr_wdata;
            CSR_INTEG_LIMIT: cfg_in.integ_limit = csr_wdata[6:0];
            default:         cfg_in = cfg_ff; // unmapped index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_duty   <= BASE_DUTY_RST;
         cfg_ff.min_duty    <= MIN_DUTY_RST;
         cfg_ff.max_duty    <= MAX_DUTY_RST;
         cfg_ff.prop_gain   <= PROP_GAIN_RST;
         cfg_ff.integ_gain  <= INTEG_GAIN_RST;
         cfg_ff.deriv_gain  <= DERIV_GAIN_RST;
         cfg_ff.integ_limit <= INTEG_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- rtl/lsps_classify.sv -----
`default_nettype none

module lsps_classify import lsps_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  frame_type     frame,
   input  logic [6:0]    integ_limit,
   output logic          stage_valid,
   input  logic          stage_ready,
   output err_stage_type stage
);

   logic                     in_fire;
   logic                     all_black;
   logic signed [ERR_W-1:0]  err;
   logic signed [SUM_W:0]    sum_raw;
   logic signed [SUM_W:0]    lim_pos;
   logic signed [SUM_W:0]    lim_neg;
   logic signed [SUM_W:0]    sum_clamped;

   logic signed [ERR_W-1:0]  last_error_ff, last_error_in;
   logic signed [SUM_W-1:0]  error_sum_ff, error_sum_in;
   logic                     valid_ff, valid_in;
   err_stage_type            stage_ff, stage_in;

   assign in_ready = !valid_ff || stage_ready;
   assign in_fire  = in_valid && in_ready;

   always_comb begin
      all_black = (frame.far_left == '0) && (frame.left == '0) && (frame.mid == '0) &&
                  (frame.right == '0) && (frame.far_right == '0);
      if (all_black) begin
         // lost the line: push hard towards the side it was last seen
         err = (last_error_ff > 0) ? LOST_ERR : -LOST_ERR;
      end else if (frame.left == '0 && frame.right == LINE_LEVEL) begin
         err = SIDE_ERR;
      end else if (frame.left == LINE_LEVEL && frame.right == '0) begin
         err = -SIDE_ERR;
      end else begin
         err = '0;
      end

      // integral clamp, upper bound tested first
      sum_raw = (SUM_W+1)'(error_sum_ff) + (SUM_W+1)'(err);
      lim_pos = $signed({2'b00, integ_limit});
      lim_neg = -lim_pos;
      if (sum_raw > lim_pos)       sum_clamped = lim_pos;
      else if (sum_raw < lim_neg)  sum_clamped = lim_neg;
      else                         sum_clamped = sum_raw;

      stage_in.err  = err;
      stage_in.diff = DIFF_W'(err) - DIFF_W'(last_error_ff);
      stage_in.sum  = sum_clamped[SUM_W-1:0];

      last_error_in = in_fire ? err : last_error_ff;
      error_sum_in  = in_fire ? sum_clamped[SUM_W-1:0] : error_sum_ff;
      valid_in      = in_fire ? 1'b1 : (valid_ff && !stage_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
         error_sum_ff  <= '0;
         valid_ff      <= 1'b0;
      end else begin
         last_error_ff <= last_error_in;
         error_sum_ff  <= error_sum_in;
         valid_ff      <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage       = stage_ff;

   a_fire_fills: assert property (@(posedge clock) disable iff (reset)
      in_fire |=> valid_ff)
      else $error("accepted beat did not reach error stage");

   a_last_tracks: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (last_error_ff == stage_ff.err))
      else $error("previous error out of step with staged error");

   a_err_codes: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (stage_ff.err == LOST_ERR || stage_ff.err == -LOST_ERR ||
                    stage_ff.err == SIDE_ERR || stage_ff.err == -SIDE_ERR ||
                    stage_ff.err == '0))
      else $error("staged error not a legal code");

   a_sum_staged: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (error_sum_ff == stage_ff.sum))
      else $error("integral out of step with staged sum");

endmodule

`default_nettype wire

// ----- rtl/lsps_pid.sv -----
`default_nettype none

module lsps_pid import lsps_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     stage_valid,
   output logic                     stage_ready,
   input  err_stage_type            stage,
   input  csr_type                  cfg,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [DUTY_W-1:0]        left_duty_q4,
   output logic [DUTY_W-1:0]        right_duty_q4,
   output logic signed [CORR_W-1:0] correction_q4,
   output logic signed [ERR_W-1:0]  position_error
);

   localparam int WIDE_W = CORR_W + 1;

   function automatic logic signed [WIDE_W-1:0] clamp_hi_first(
      input logic signed [WIDE_W-1:0] v,
      input logic signed [WIDE_W-1:0] lo,
      input logic signed [WIDE_W-1:0] hi);
      logic signed [WIDE_W-1:0] r;
      if (v > hi)      r = hi;
      else if (v < lo) r = lo;
      else             r = v;
      return r;
   endfunction

   logic                     take;
   logic signed [CORR_W-1:0] p_term, i_term, d_term, corr;
   logic signed [WIDE_W-1:0] base_w, lo_w, hi_w, left_w, right_w;

   logic                     valid_ff, valid_in;
   logic [DUTY_W-1:0]        left_ff, right_ff;
   logic signed [CORR_W-1:0] corr_ff;
   logic signed [ERR_W-1:0]  err_ff;

   assign stage_ready = !valid_ff || out_ready;
   assign take        = stage_valid && stage_ready;

   always_comb begin
      p_term = $signed({9'd0, cfg.prop_gain})  * CORR_W'(stage.err);
      i_term = $signed({9'd0, cfg.integ_gain}) * CORR_W'(stage.sum);
      d_term = $signed({9'd0, cfg.deriv_gain}) * CORR_W'(stage.diff);
      corr   = p_term + i_term + d_term;

      // duties in sixteenths of a percent
      base_w  = $signed({7'd0, cfg.base_duty, 4'd0});
      lo_w    = $signed({7'd0, cfg.min_duty, 4'd0});
      hi_w    = $signed({7'd0, cfg.max_duty, 4'd0});
      left_w  = clamp_hi_first(base_w - WIDE_W'(corr), lo_w, hi_w);
      right_w = clamp_hi_first(base_w + WIDE_W'(corr), lo_w, hi_w);

      valid_in = take ? 1'b1 : (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         left_ff  <= left_w[DUTY_W-1:0];
         right_ff <= right_w[DUTY_W-1:0];
         corr_ff  <= corr;
         err_ff   <= stage.err;
      end
   end

   assign out_valid      = valid_ff;
   assign left_duty_q4   = left_ff;
   assign right_duty_q4  = right_ff;
   assign correction_q4  = corr_ff;
   assign position_error = err_ff;

endmodule

`default_nettype wire

// ----- rtl/line_sensor_pd_steering_top.sv -----
// Line-sensor PD(I) steering block.
// req_chan carries one frame of five sensor readings per beat (valid/ready).
// Each frame is classified into a position error (+/-25 line lost, +/-10
// line off to one side, else 0); a PID correction in sixteenths of a duty
// percent is formed from Q4.4 gains and the left/right wheel duties are
// base -/+ correction, saturated to [min, max], returned on rsp_chan.
// An accepted req beat passes the error stage register, then the result
// register, to rsp valid. Throughput: one beat per cycle while rsp ready is
// high, set by the previous-error and integral registers, updated per beat.
// Stalls: when rsp ready is low the result register holds; an empty error
// stage takes one more beat, then req ready drops until rsp drains.
// Reset (synchronous, active high): previous error and integral to zero,
// all pipeline valids cleared, CSRs to their defaults (68/55/85/56/0/20/30).
// CSRs: csr_we with csr_index 0..6 (base, min, max, Kp, Ki, Kd, limit);
// other indices ignored. Write only while the block is idle.
`default_nettype none

module line_sensor_pd_steering_top import lsps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   lsps_req_if.sink              req_chan,
   lsps_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   csr_type       cfg;
   frame_type     frame;
   err_stage_type stage;
   logic          stage_valid;
   logic          stage_ready;

   // register file
   lsps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign frame.far_left  = req_chan.sensor_far_left;
   assign frame.left      = req_chan.sensor_left;
   assign frame.mid       = req_chan.sensor_mid;
   assign frame.right     = req_chan.sensor_right;
   assign frame.far_right = req_chan.sensor_far_right;

   // stage 1: error classification, integral and previous-error state
   lsps_classify u_classify (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_chan.valid),
      .in_ready    (req_chan.ready),
      .frame       (frame),
      .integ_limit (cfg.integ_limit),
      .stage_valid (stage_valid),
      .stage_ready (stage_ready),
      .stage       (stage)
   );

   // stage 2: multiply-add and duty saturation into the result register
   lsps_pid u_pid (
      .clock          (clock),
      .reset          (reset),
      .stage_valid    (stage_valid),
      .stage_ready    (stage_ready),
      .stage          (stage),
      .cfg            (cfg),
      .out_valid      (rsp_chan.valid),
      .out_ready      (rsp_chan.ready),
      .left_duty_q4   (rsp_chan.left_duty_q4),
      .right_duty_q4  (rsp_chan.right_duty_q4),
      .correction_q4  (rsp_chan.correction_q4),
      .position_error (rsp_chan.position_error)
   );

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Steering block testbench: frames in on req_chan, duty results out on rsp_chan.

module testbench import lsps_pkg::*; ();

   localparam int SET_ITEMS   = 108;     // random frames per register setting
   localparam int SETTINGS_N  = 10;      // register settings after the directed part
   localparam int HOLD_CYCLES = 60;      // long receiver hold-off, fills the pipe
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;   // decodes to nothing

   // kinds of frame the random part is built from
   typedef enum int {
      FR_LOST,      // all black
      FR_RIGHT,     // left black, right on the line
      FR_LEFT,      // mirrored
      FR_MIXED      // anything else, odd readings included
   } frame_kind_type;

   typedef struct packed {
      logic [DUTY_W-1:0]        left_duty;
      logic [DUTY_W-1:0]        right_duty;
      logic signed [CORR_W-1:0] correction;
      logic signed [ERR_W-1:0]  pos_err;
   } steer_result_type;

   // Predicts the duty beat for every accepted frame and checks the block's beats
   // against it, oldest first.
   class steering_scoreboard;
      csr_type                 regs;
      logic signed [ERR_W-1:0] prev_err;
      logic signed [SUM_W-1:0] err_sum;
      steer_result_type        pending_duties[$];
      int                      fails;
      int                      n_results;

      function new();
         regs.base_duty   = BASE_DUTY_RST;
         regs.min_duty    = MIN_DUTY_RST;
         regs.max_duty    = MAX_DUTY_RST;
         regs.prop_gain   = PROP_GAIN_RST;
         regs.integ_gain  = INTEG_GAIN_RST;
         regs.deriv_gain  = DERIV_GAIN_RST;
         regs.integ_limit = INTEG_LIMIT_RST;
         prev_err  = '0;
         err_sum   = '0;
         fails     = 0;
         n_results = 0;
      endfunction

      function void report(input string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         fails++;
      endfunction

      function int pending();
         return pending_duties.size();
      endfunction

      // 7-bit registers keep the low seven bits of the write data
      function void set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
         case (idx)
            CSR_BASE_DUTY:   regs.base_duty   = val[6:0];
            CSR_MIN_DUTY:    regs.min_duty    = val[6:0];
            CSR_MAX_DUTY:    regs.max_duty    = val[6:0];
            CSR_PROP_GAIN:   regs.prop_gain   = val;
            CSR_INTEG_GAIN:  regs.integ_gain  = val;
            CSR_DERIV_GAIN:  regs.deriv_gain  = val;
            CSR_INTEG_LIMIT: regs.integ_limit = val[6:0];
            default: ;
         endcase
      endfunction

      // upper bound wins when min is above max
      function int saturate(input int v, input int lo, input int hi);
         if (v > hi)
            return hi;
         if (v < lo)
            return lo;
         return v;
      endfunction

      function void note_frame(input frame_type f);
         int               e;
         int               sum;
         int               lim;
         int               corr;
         int               base;
         int               lo;
         int               hi;
         steer_result_type r;
         if (f == '0)
            e = (prev_err > 0) ? int'(LOST_ERR) : -int'(LOST_ERR);
         else if (f.left == '0 && f.right == LINE_LEVEL)
            e = int'(SIDE_ERR);
         else if (f.left == LINE_LEVEL && f.right == '0)
            e = -int'(SIDE_ERR);
         else
            e = 0;
         lim  = int'(regs.integ_limit);
         sum  = saturate(int'(err_sum) + e, -lim, lim);
         corr = int'(regs.prop_gain) * e + int'(regs.integ_gain) * sum
              + int'(regs.deriv_gain) * (e - int'(prev_err));
         err_sum  = sum[SUM_W-1:0];
         prev_err = e[ERR_W-1:0];
         base = int'(regs.base_duty) * 16;
         lo   = int'(regs.min_duty) * 16;
         hi   = int'(regs.max_duty) * 16;
         r.left_duty  = DUTY_W'(saturate(base - corr, lo, hi));
         r.right_duty = DUTY_W'(saturate(base + corr, lo, hi));
         r.correction = corr[CORR_W-1:0];
         r.pos_err    = e[ERR_W-1:0];
         pending_duties.push_back(r);
      endfunction

      function void check_result(input steer_result_type got);
         steer_result_type want;
         n_results++;
         if (pending_duties.size() == 0) begin
            report($sformatf("result beat %0d arrived with nothing pending", n_results));
            return;
         end
         want = pending_duties.pop_front();
         if (got.left_duty !== want.left_duty)
            report($sformatf("beat %0d left duty %0d, want %0d",
                             n_results, got.left_duty, want.left_duty));
         if (got.right_duty !== want.right_duty)
            report($sformatf("beat %0d right duty %0d, want %0d",
                             n_results, got.right_duty, want.right_duty));
         if (got.correction !== want.correction)
            report($sformatf("beat %0d correction %0d, want %0d",
                             n_results, got.correction, want.correction));
         if (got.pos_err !== want.pos_err)
            report($sformatf("beat %0d position error %0d, want %0d",
                             n_results, got.pos_err, want.pos_err));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // idle rates in percent, changed between register settings only
   int   src_idle_pct  = 31;
   int   sink_idle_pct = 74;
   logic hold_req      = 1'b0;
   logic holding       = 1'b0;

   steering_scoreboard sb = new();

   lsps_req_if req_bus ();
   lsps_rsp_if rsp_bus ();

   line_sensor_pd_steering_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Monitor: both channels sampled on the rising edge. The result beat is
   // checked before the frame beat of the same edge is noted; a frame passes the
   // error stage and result registers first, so the two never belong together.
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            sb.check_result('{left_duty:  rsp_bus.left_duty_q4,
                              right_duty: rsp_bus.right_duty_q4,
                              correction: rsp_bus.correction_q4,
                              pos_err:    rsp_bus.position_error});
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            sb.note_frame('{far_left:  req_bus.sensor_far_left,
                            left:      req_bus.sensor_left,
                            mid:       req_bus.sensor_mid,
                            right:     req_bus.sensor_right,
                            far_right: req_bus.sensor_far_right});
      end
   end

   // Receiver: random back-pressure, plus the long hold-off while holding is up.
   always @(negedge clock)
      rsp_bus.ready <= !holding && ($urandom_range(99) >= sink_idle_pct);

   // Hold-off counter in its own process. Holding flips on the rising edge so
   // the receiver never reads it in the same step that it changes.
   initial begin
      forever begin
         wait (hold_req);
         hold_req = 1'b0;
         @(posedge clock);
         holding = 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         holding = 1'b0;
      end
   end

   function automatic frame_type mk(input int fl, input int l, input int m, input int r,
                                    input int fr);
      frame_type f;
      f.far_left  = SENSOR_W'(fl);
      f.left      = SENSOR_W'(l);
      f.mid       = SENSOR_W'(m);
      f.right     = SENSOR_W'(r);
      f.far_right = SENSOR_W'(fr);
      return f;
   endfunction

   // mostly clean black/line readings, some arbitrary codes
   function automatic logic [SENSOR_W-1:0] pick_reading();
      int k;
      k = $urandom_range(9);
      if (k < 4)
         return '0;
      if (k < 8)
         return LINE_LEVEL;
      return SENSOR_W'($urandom_range(1023));
   endfunction

   function automatic frame_type rand_frame(input frame_kind_type kind);
      frame_type f;
      f.far_left  = pick_reading();
      f.left      = pick_reading();
      f.mid       = pick_reading();
      f.right     = pick_reading();
      f.far_right = pick_reading();
      case (kind)
         FR_LOST:  f = '0;
         FR_RIGHT: begin
            f.left  = '0;
            f.right = LINE_LEVEL;
         end
         FR_LEFT:  begin
            f.left  = LINE_LEVEL;
            f.right = '0;
         end
         default: ;
      endcase
      return f;
   endfunction

   // One frame beat: random gap first, then hold valid until the block takes it.
   task automatic send_frame(input frame_type f);
      @(negedge clock);
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.sensor_far_left  <= f.far_left;
      req_bus.sensor_left      <= f.left;
      req_bus.sensor_mid       <= f.mid;
      req_bus.sensor_right     <= f.right;
      req_bus.sensor_far_right <= f.far_right;
      @(posedge clock);
      while (req_bus.ready !== 1'b1)
         @(posedge clock);
   endtask

   // Stop offering frames and wait for every predicted beat; every frame gives
   // a result, so this empties the two-stage pipe before the spare cycles.
   task automatic drain();
      int guard;
      guard = 0;
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   // Settings 0..2 are the corners; the rest are random, half in range and
   // half at full register width.
   task automatic program_regs(input int p);
      csr_index_type idx;
      case (p)
         0: begin                          // full swing, all gains at maximum
            write_reg(CSR_BASE_DUTY,   8'd0);
            write_reg(CSR_MIN_DUTY,    8'd0);
            write_reg(CSR_MAX_DUTY,    8'd100);
            write_reg(CSR_PROP_GAIN,   8'd255);
            write_reg(CSR_INTEG_GAIN,  8'd255);
            write_reg(CSR_DERIV_GAIN,  8'd255);
            write_reg(CSR_INTEG_LIMIT, 8'd100);
         end
         1: begin                          // min above max, zero integral limit
            write_reg(CSR_BASE_DUTY,   8'd100);
            write_reg(CSR_MIN_DUTY,    8'd100);
            write_reg(CSR_MAX_DUTY,    8'd0);
            write_reg(CSR_PROP_GAIN,   8'd0);
            write_reg(CSR_INTEG_GAIN,  8'd255);
            write_reg(CSR_DERIV_GAIN,  8'd0);
            write_reg(CSR_INTEG_LIMIT, 8'd0);
         end
         2: begin                          // every bit set, 7-bit regs see 127
            idx = idx.first();
            do begin
               write_reg(idx, 8'hFF);
               idx = idx.next();
            end while (idx != idx.first());
         end
         default: begin
            idx = idx.first();
            do begin
               write_reg(idx, $urandom_range(1) ? 8'($urandom_range(100))
                                                : 8'($urandom_range(255)));
               idx = idx.next();
            end while (idx != idx.first());
            if (p == 3)
               write_reg(CSR_UNUSED, 8'($urandom_range(255)));
         end
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Stimulus
   initial begin
      frame_type      directed[$];
      frame_kind_type kind;
      int             sent;
      int             run;
      int             guard;

      reset                    = 1'b1;
      csr_we                   = 1'b0;
      csr_index                = '0;
      csr_wdata                = '0;
      rsp_bus.ready            = 1'b0;
      req_bus.valid            = 1'b0;
      req_bus.sensor_far_left  = '0;
      req_bus.sensor_left      = '0;
      req_bus.sensor_mid       = '0;
      req_bus.sensor_right     = '0;
      req_bus.sensor_far_right = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part on the reset registers. Lost line with no previous
      // error goes negative; after a positive error it goes positive.
      directed.push_back(mk(0, 0, 0, 0, 0));               // lost, previous zero
      directed.push_back(mk(0, 0, 0, 0, 0));               // lost, previous negative
      directed.push_back(mk(0, 0, 0, 1000, 0));            // line to the right
      directed.push_back(mk(0, 0, 0, 0, 0));               // lost, previous positive
      directed.push_back(mk(1000, 1000, 1000, 1000, 1000)); // both on the line
      directed.push_back(mk(0, 1000, 0, 0, 0));            // line to the left
      directed.push_back(mk(0, 0, 0, 0, 0));
      directed.push_back(mk(1023, 0, 1000, 1000, 1023));   // right, odd outer codes
      directed.push_back(mk(0, 999, 0, 0, 0));             // near-line codes count as neither
      directed.push_back(mk(0, 0, 0, 1001, 0));
      directed.push_back(mk(0, 1023, 0, 0, 0));
      directed.push_back(mk(1023, 0, 0, 0, 0));            // not all black
      directed.push_back(mk(0, 0, 0, 0, 1));
      directed.push_back(mk(0, 0, 1, 0, 0));
      directed.push_back(mk(0, 1, 0, 1000, 0));
      // a run right drives the integral into its upper clamp, then lost right
      repeat (5) directed.push_back(mk(0, 0, 0, 1000, 0));
      directed.push_back(mk(0, 0, 0, 0, 0));
      // and the mirror into the lower clamp
      repeat (4) directed.push_back(mk(1000, 1000, 0, 0, 0));
      directed.push_back(mk(0, 0, 0, 0, 0));
      foreach (directed[i])
         send_frame(directed[i]);

      // Random part: one block of frames per register setting. Idling: sender
      // light and receiver heavy first, then swapped, then none at all.
      for (int p = 0; p < SETTINGS_N; p++) begin
         drain();
         if (p < 3) begin
            src_idle_pct  = 31;
            sink_idle_pct = 74;
         end else if (p < 6) begin
            src_idle_pct  = 74;
            sink_idle_pct = 31;
         end else begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
         end
         program_regs(p);
         // long receiver hold-off while frames keep coming: req ready must drop
         if (p == 0 || p == 6)
            hold_req = 1'b1;
         sent = 0;
         while (sent < SET_ITEMS) begin
            // runs of one kind reach the integral clamps and the lost-line sign
            kind = frame_kind_type'($urandom_range(3));
            run  = $urandom_range(1, 8);
            for (int k = 0; k < run && sent < SET_ITEMS; k++) begin
               send_frame(rand_frame(kind));
               sent++;
            end
         end
      end

      drain();
      guard = 0;
      while (guard < 10) begin
         @(posedge clock);
         guard++;
      end
      if (sb.pending() != 0)
         sb.report($sformatf("%0d expected result beats never arrived", sb.pending()));
      if (sb.fails == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #4000000;
      $display("timeout: %0d result beats still pending", sb.pending());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/lsps_pkg.sv
rtl/lsps_if.sv
rtl/lsps_csr.sv
rtl/lsps_classify.sv
rtl/lsps_pid.sv
rtl/line_sensor_pd_steering_top.sv
sim/testbench.sv
